FILE: design/rpbb_pkg.sv
// Shared constants and types of the rotator positioner.
package rpbb_pkg;

    // Default width of the position sensor ADC counts.
    localparam int ADC_BITS_DEF = 10;

    // Configuration port.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RES_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AZ_ZERO = 3'd0,
        CFG_AZ_MAX  = 3'd1,
        CFG_AZ_DZ   = 3'd2,
        CFG_AZ_RES  = 3'd3,
        CFG_EL_ZERO = 3'd4,
        CFG_EL_MAX  = 3'd5,
        CFG_EL_DZ   = 3'd6,
        CFG_EL_RES  = 3'd7
    } cfg_idx_t;

    // Register values after reset.
    localparam int ZERO_RST   = 0;
    localparam int MAX_RST    = 1023;
    localparam int DZ_RST     = 4;
    localparam int AZ_RES_RST = 28836;
    localparam int EL_RES_RST = 11534;

    // Target and readback fields.
    localparam int AZ_TGT_W   = 9;
    localparam int EL_TGT_W   = 8;
    localparam int AZ_DEG_W   = 9;
    localparam int EL_DEG_W   = 8;
    localparam int AZ_DEG_MAX = 450;
    localparam int EL_DEG_MAX = 180;

    // Dividend of the goal conversion: deg * 2^17 + res fits in 26 bits.
    localparam int FRAC_SH = 17;
    localparam int NUM_W   = AZ_TGT_W + FRAC_SH;
    localparam int DEN_W   = RES_W + 1;

endpackage

FILE: design/rpbb_cfg_regs.sv
// Configuration register file of the rotator positioner.
module rpbb_cfg_regs #(
    parameter int ADC_BITS = rpbb_pkg::ADC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rpbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpbb_pkg::CFG_W-1:0]     cfg_data,
    output logic [ADC_BITS-1:0]            az_zero,
    output logic [ADC_BITS-1:0]            az_max,
    output logic [ADC_BITS-1:0]            az_dz,
    output logic [rpbb_pkg::RES_W-1:0]     az_res,
    output logic [ADC_BITS-1:0]            el_zero,
    output logic [ADC_BITS-1:0]            el_max,
    output logic [ADC_BITS-1:0]            el_dz,
    output logic [rpbb_pkg::RES_W-1:0]     el_res
);
    import rpbb_pkg::*;

    logic [ADC_BITS-1:0] az_zero_reg, az_max_reg, az_dz_reg;
    logic [ADC_BITS-1:0] el_zero_reg, el_max_reg, el_dz_reg;
    logic [RES_W-1:0]    az_res_reg, el_res_reg;
    logic [ADC_BITS-1:0] cnt_data;

    assign cnt_data = cfg_data[ADC_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_zero_reg <= ADC_BITS'(ZERO_RST);
            az_max_reg  <= ADC_BITS'(MAX_RST);
            az_dz_reg   <= ADC_BITS'(DZ_RST);
            az_res_reg  <= RES_W'(AZ_RES_RST);
            el_zero_reg <= ADC_BITS'(ZERO_RST);
            el_max_reg  <= ADC_BITS'(MAX_RST);
            el_dz_reg   <= ADC_BITS'(DZ_RST);
            el_res_reg  <= RES_W'(EL_RES_RST);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_AZ_ZERO: az_zero_reg <= cnt_data;
                CFG_AZ_MAX:  az_max_reg  <= cnt_data;
                CFG_AZ_DZ:   az_dz_reg   <= cnt_data;
                CFG_AZ_RES:  az_res_reg  <= cfg_data[RES_W-1:0];
                CFG_EL_ZERO: el_zero_reg <= cnt_data;
                CFG_EL_MAX:  el_max_reg  <= cnt_data;
                CFG_EL_DZ:   el_dz_reg   <= cnt_data;
                CFG_EL_RES:  el_res_reg  <= cfg_data[RES_W-1:0];
                default:     az_zero_reg <= az_zero_reg;
            endcase
        end
    end

    assign az_zero = az_zero_reg;
    assign az_max  = az_max_reg;
    assign az_dz   = az_dz_reg;
    assign az_res  = az_res_reg;
    assign el_zero = el_zero_reg;
    assign el_max  = el_max_reg;
    assign el_dz   = el_dz_reg;
    assign el_res  = el_res_reg;

endmodule

FILE: design/rpbb_div.sv
// Restoring divider, one quotient bit per cycle, with an overflow flag.
module rpbb_div #(
    parameter int ADC_BITS = rpbb_pkg::ADC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rpbb_pkg::NUM_W-1:0] num,
    input  logic [rpbb_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic                       ovf,
    output logic [ADC_BITS-1:0]        quo
);
    import rpbb_pkg::*;

    // Working width holds both the dividend and the divisor shifted up by ADC_BITS.
    localparam int W  = (DEN_W + ADC_BITS > NUM_W) ? DEN_W + ADC_BITS : NUM_W;
    localparam int CW = $clog2(ADC_BITS + 2);

    logic [W-1:0]        rem_reg, rem_next;
    logic [W-1:0]        dsh_reg;
    logic [ADC_BITS:0]   q_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                ge;

    assign ge       = rem_reg >= dsh_reg;
    assign rem_next = ge ? rem_reg - dsh_reg : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(ADC_BITS + 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The first step tests for a quotient of 2^ADC_BITS or more; the rest
    // produce the quotient bits from the top down.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= W'(num);
            dsh_reg <= W'(den) << ADC_BITS;
            q_reg   <= '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[ADC_BITS-1:0], ge};
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign ovf  = q_reg[ADC_BITS];
    assign quo  = q_reg[ADC_BITS-1:0];

`ifndef ASSERT_OFF
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!busy_reg || done))
        else $error("divider restarted in the middle of a division");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("divider done held for more than one cycle");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ADC_BITS + 1))
        else $error("divider step count out of range");
`endif

endmodule

FILE: design/rotator_position_bang_bang.sv
// Top level of the two-axis antenna rotator positioner with dead-zone bang-bang control.
//
// Each input item (in_valid/in_ready) carries both ADC samples and, when operation
// is 1, new target degrees. Each item gives exactly one result item
// (out_valid/out_ready) with the four drive lines, the busy flag and both samples
// read back as degrees. A command converts its targets to goal counts on one
// shared restoring divider, azimuth first, then elevation, one quotient bit per
// cycle; the readback products go through one shared multiplier meanwhile.
// A sample tick steps through ST_MUL_AZ, ST_MUL_EL and ST_FIN to its result; a
// command steps through ST_AZ_DIV and ST_EL_DIV, one divider run each, then ST_FIN.
// The block takes the next item only once it is back in ST_IDLE, so it takes
// one item at a time.
// The result sits in an output register: a stalled receiver does not keep the
// block from accepting and working on the next item, which waits in its final
// step until the output register is free. Configuration writes are taken at any
// cycle with cfg_write high and must only be made while the block is idle.
// Reset restores the register defaults, clears both goals, the motion phase and
// the output register, and the block is ready in the first cycle after reset.
module rotator_position_bang_bang #(
    parameter int ADC_BITS = rpbb_pkg::ADC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port.
    input  logic                           cfg_write,
    input  logic [rpbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpbb_pkg::CFG_W-1:0]     cfg_data,
    // Input item channel.
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [ADC_BITS-1:0]            az_sample,
    input  logic [ADC_BITS-1:0]            el_sample,
    input  logic [rpbb_pkg::AZ_TGT_W-1:0]  az_target_deg,
    input  logic [rpbb_pkg::EL_TGT_W-1:0]  el_target_deg,
    // Result item channel.
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           drive_east,
    output logic                           drive_west,
    output logic                           drive_up,
    output logic                           drive_down,
    output logic                           busy_res,
    output logic [rpbb_pkg::AZ_DEG_W-1:0]  az_degrees,
    output logic [rpbb_pkg::EL_DEG_W-1:0]  el_degrees
);
    import rpbb_pkg::*;

    localparam int PROD_W = ADC_BITS + RES_W;
    localparam int EXT_W  = (ADC_BITS > AZ_DEG_W) ? ADC_BITS : AZ_DEG_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AZ_DIV,
        ST_EL_DIV,
        ST_MUL_AZ,
        ST_MUL_EL,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_AZ   = 2'd1,
        PH_EL   = 2'd2
    } phase_t;

    // Configuration registers.
    logic [ADC_BITS-1:0] az_zero, az_max, az_dz, el_zero, el_max, el_dz;
    logic [RES_W-1:0]    az_res, el_res;

    // Sequencer and item state.
    state_t                state_reg;
    phase_t                phase_reg, phase_next;
    logic                  cmd_reg;
    logic [ADC_BITS-1:0]   az_s_reg, el_s_reg;
    logic [EL_TGT_W-1:0]   el_tgt_reg;
    logic [ADC_BITS-1:0]   az_goal_reg, el_goal_reg;
    logic [ADC_BITS-1:0]   az_dhi_reg, el_dhi_reg;

    // Output register.
    logic                  out_valid_reg;
    logic                  east_reg, west_reg, up_reg, down_reg, busy_reg;
    logic [AZ_DEG_W-1:0]   az_deg_reg;
    logic [EL_DEG_W-1:0]   el_deg_reg;

    logic                  in_accept;
    logic                  slot_free;

    // Divider interface.
    logic                  div_start, div_done, div_ovf;
    logic [ADC_BITS-1:0]   div_quo;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;

    // Goal clamp, shared between the axes.
    logic                  g_is_az;
    logic [ADC_BITS-1:0]   g_zero, g_max, g_hi, goal_new;
    logic [ADC_BITS:0]     goal_sum;
    logic                  g_sat;

    // Readback multiplier, shared between the axes.
    logic                  m_is_az;
    logic [ADC_BITS-1:0]   m_s, m_zero, m_diff;
    logic [RES_W-1:0]      m_res;
    logic [PROD_W-1:0]     m_prod;
    logic [ADC_BITS-1:0]   m_hi;

    // Motion decision.
    logic [ADC_BITS-1:0]   az_err, el_err;
    logic                  az_move, el_move;
    logic                  east_n, west_n, up_n, down_n;
    logic [AZ_DEG_W-1:0]   az_deg_n;
    logic [EL_DEG_W-1:0]   el_deg_n;

    rpbb_cfg_regs #(
        .ADC_BITS (ADC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .az_zero   (az_zero),
        .az_max    (az_max),
        .az_dz     (az_dz),
        .az_res    (az_res),
        .el_zero   (el_zero),
        .el_max    (el_max),
        .el_dz     (el_dz),
        .el_res    (el_res)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // The azimuth division starts straight from the ports at acceptance; the
    // elevation division starts in the cycle the azimuth one finishes.
    // The dividend deg * 2^17 + res over 2 * res gives deg / res rounded half up.
    assign div_start = (in_accept && operation) || (state_reg == ST_AZ_DIV && div_done);

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            div_num = (NUM_W'(az_target_deg) << FRAC_SH) + NUM_W'(az_res);
            div_den = {az_res, 1'b0};
        end
        else
        begin
            div_num = (NUM_W'(el_tgt_reg) << FRAC_SH) + NUM_W'(el_res);
            div_den = {el_res, 1'b0};
        end
    end

    rpbb_div #(
        .ADC_BITS (ADC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .ovf   (div_ovf),
        .quo   (div_quo)
    );

    // Goal = quotient + zero, clamped to max and then to zero. A zero
    // resolution shows up as an overflow and lands on max as well.
    assign g_is_az  = (state_reg == ST_AZ_DIV);
    assign g_zero   = g_is_az ? az_zero : el_zero;
    assign g_max    = g_is_az ? az_max : el_max;
    assign goal_sum = {1'b0, div_quo} + {1'b0, g_zero};
    assign g_sat    = div_ovf || (goal_sum > {1'b0, g_max});
    assign g_hi     = g_sat ? g_max : goal_sum[ADC_BITS-1:0];
    assign goal_new = (g_hi < g_zero) ? g_zero : g_hi;

    // Readback: integer part of (sample - zero) * res in Q0.16, 0 at or below zero.
    assign m_is_az = (state_reg == ST_AZ_DIV) || (state_reg == ST_MUL_AZ);
    assign m_s     = m_is_az ? az_s_reg : el_s_reg;
    assign m_zero  = m_is_az ? az_zero : el_zero;
    assign m_res   = m_is_az ? az_res : el_res;
    assign m_diff  = (m_s > m_zero) ? m_s - m_zero : '0;
    assign m_prod  = PROD_W'(m_diff) * PROD_W'(m_res);
    assign m_hi    = m_prod[PROD_W-1:RES_W];

    assign az_deg_n = (EXT_W'(az_dhi_reg) > EXT_W'(AZ_DEG_MAX)) ?
                      AZ_DEG_W'(AZ_DEG_MAX) : AZ_DEG_W'(az_dhi_reg);
    assign el_deg_n = (EXT_W'(el_dhi_reg) > EXT_W'(EL_DEG_MAX)) ?
                      EL_DEG_W'(EL_DEG_MAX) : EL_DEG_W'(el_dhi_reg);

    // A move starts only when the error exceeds the dead zone.
    assign az_err  = (az_s_reg > az_goal_reg) ? az_s_reg - az_goal_reg
                                              : az_goal_reg - az_s_reg;
    assign el_err  = (el_s_reg > el_goal_reg) ? el_s_reg - el_goal_reg
                                              : el_goal_reg - el_s_reg;
    assign az_move = az_err > az_dz;
    assign el_move = el_err > el_dz;

    // Phase update and drive lines for the finished item. A command restarts
    // the sequence; azimuth arrival hands over to elevation in the same item if
    // elevation is beyond its dead zone, else ends the motion; elevation arrival ends it.
    always_comb
    begin
        phase_t ph;
        ph     = phase_reg;
        east_n = 1'b0;
        west_n = 1'b0;
        up_n   = 1'b0;
        down_n = 1'b0;
        if (cmd_reg)
        begin
            if (az_move)
            begin
                ph = PH_AZ;
            end
            else if (el_move)
            begin
                ph = PH_EL;
            end
            else
            begin
                ph = PH_IDLE;
            end
        end
        else if (phase_reg == PH_AZ && az_s_reg == az_goal_reg)
        begin
            ph = el_move ? PH_EL : PH_IDLE;
        end
        phase_next = ph;
        unique case (ph)
            PH_AZ:
            begin
                east_n = az_s_reg < az_goal_reg;
                west_n = az_s_reg > az_goal_reg;
            end
            PH_EL:
            begin
                up_n   = el_s_reg < el_goal_reg;
                down_n = el_s_reg > el_goal_reg;
                if (el_s_reg == el_goal_reg)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            cmd_reg       <= 1'b0;
            az_s_reg      <= '0;
            el_s_reg      <= '0;
            el_tgt_reg    <= '0;
            az_goal_reg   <= '0;
            el_goal_reg   <= '0;
            az_dhi_reg    <= '0;
            el_dhi_reg    <= '0;
            out_valid_reg <= 1'b0;
            east_reg      <= 1'b0;
            west_reg      <= 1'b0;
            up_reg        <= 1'b0;
            down_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            az_deg_reg    <= '0;
            el_deg_reg    <= '0;
        end
        else
        begin
            // In the final step the output register is refilled below instead.
            if (out_valid_reg && out_ready && state_reg != ST_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        cmd_reg    <= operation;
                        az_s_reg   <= az_sample;
                        el_s_reg   <= el_sample;
                        el_tgt_reg <= el_target_deg;
                        state_reg  <= operation ? ST_AZ_DIV : ST_MUL_AZ;
                    end
                end
                ST_AZ_DIV:
                begin
                    az_dhi_reg <= m_hi;
                    if (div_done)
                    begin
                        az_goal_reg <= goal_new;
                        state_reg   <= ST_EL_DIV;
                    end
                end
                ST_EL_DIV:
                begin
                    el_dhi_reg <= m_hi;
                    if (div_done)
                    begin
                        el_goal_reg <= goal_new;
                        state_reg   <= ST_FIN;
                    end
                end
                ST_MUL_AZ:
                begin
                    az_dhi_reg <= m_hi;
                    state_reg  <= ST_MUL_EL;
                end
                ST_MUL_EL:
                begin
                    el_dhi_reg <= m_hi;
                    state_reg  <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (slot_free)
                    begin
                        phase_reg     <= phase_next;
                        out_valid_reg <= 1'b1;
                        east_reg      <= east_n;
                        west_reg      <= west_n;
                        up_reg        <= up_n;
                        down_reg      <= down_n;
                        busy_reg      <= (phase_next != PH_IDLE);
                        az_deg_reg    <= az_deg_n;
                        el_deg_reg    <= el_deg_n;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign drive_east = east_reg;
    assign drive_west = west_reg;
    assign drive_up   = up_reg;
    assign drive_down = down_reg;
    assign busy_res   = busy_reg;
    assign az_degrees = az_deg_reg;
    assign el_degrees = el_deg_reg;

`ifndef ASSERT_OFF
    a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({drive_east, drive_west, drive_up, drive_down}))
        else $error("more than one drive line active");
    a_idle_still: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |->
        !(drive_east || drive_west || drive_up || drive_down))
        else $error("drive line active while no motion is in progress");
    a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (az_degrees <= AZ_DEG_W'(AZ_DEG_MAX) &&
                       el_degrees <= EL_DEG_W'(EL_DEG_MAX)))
        else $error("readback degrees beyond limit");
    a_div_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_AZ_DIV || state_reg == ST_EL_DIV))
        else $error("divider finished outside a conversion step");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the two-axis rotator positioner.
module tb_top;
    import rpbb_pkg::*;

    localparam int CNT_W            = ADC_BITS_DEF;
    localparam int CNT_TOP          = (1 << CNT_W) - 1;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 162;
    localparam int HOLD_CYCLES      = 400;
    localparam int IDLE_PCT         = 16;
    localparam int DRAIN_CYCLES     = 40;

    // Motion phase of the positioner as the predictor tracks it.
    typedef enum logic [1:0] {
        MV_IDLE,
        MV_AZ,
        MV_EL
    } motion_t;

    // The operation field of an input item.
    typedef enum logic {
        OP_TICK,
        OP_CMD
    } op_t;

    // One result item: the four drive lines, busy and the two readbacks.
    typedef struct packed {
        logic                east;
        logic                west;
        logic                up;
        logic                down;
        logic                busy;
        logic [AZ_DEG_W-1:0] az_deg;
        logic [EL_DEG_W-1:0] el_deg;
    } drive_word_t;

    // One row of the directed table. A typed row carries its result as written
    // down by hand; the other rows are checked against the predictor.
    typedef struct {
        op_t                 op;
        logic [CNT_W-1:0]    az;
        logic [CNT_W-1:0]    el;
        logic [AZ_TGT_W-1:0] azt;
        logic [EL_TGT_W-1:0] elt;
        bit                  typed;
        drive_word_t         want;
    } table_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 operation;
    logic [CNT_W-1:0]     az_sample;
    logic [CNT_W-1:0]     el_sample;
    logic [AZ_TGT_W-1:0]  az_target_deg;
    logic [EL_TGT_W-1:0]  el_target_deg;
    logic                 out_valid;
    logic                 out_ready;
    logic                 drive_east;
    logic                 drive_west;
    logic                 drive_up;
    logic                 drive_down;
    logic                 busy_res;
    logic [AZ_DEG_W-1:0]  az_degrees;
    logic [EL_DEG_W-1:0]  el_degrees;

    // Shadow copy of the configuration registers.
    logic [CNT_W-1:0] az_zero_c;
    logic [CNT_W-1:0] az_max_c;
    logic [CNT_W-1:0] az_dz_c;
    logic [RES_W-1:0] az_res_c;
    logic [CNT_W-1:0] el_zero_c;
    logic [CNT_W-1:0] el_max_c;
    logic [CNT_W-1:0] el_dz_c;
    logic [RES_W-1:0] el_res_c;

    // Predicted state of the positioner, advanced on every accepted item.
    logic [CNT_W-1:0] az_goal_p;
    logic [CNT_W-1:0] el_goal_p;
    motion_t          motion_p;

    // Result items that the positioner still owes, oldest first.
    drive_word_t drive_words_due[$];
    table_row_t  script[$];

    // The item on offer: whether its result was typed in, and that result.
    bit          row_typed;
    drive_word_t row_want;

    // Where the simulated antenna points; the sensor samples follow it.
    logic [CNT_W-1:0] az_pos;
    logic [CNT_W-1:0] el_pos;

    bit idle_on;
    bit hold_req;
    int errors;
    int cycles;

    rotator_position_bang_bang i_dut (.*);

    // The clock runs with a period of 10 time units.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Converts target degrees to a goal count: the quotient rounded half up,
    // offset by the zero count, clamped first to the max and then to the zero.
    // A zero resolution stands for an unbounded quotient, so the max clamp wins.
    function automatic logic [CNT_W-1:0] goal_count(input int unsigned deg,
                                                    input int unsigned res,
                                                    input int unsigned zero,
                                                    input int unsigned top);
        longint unsigned num;
        longint unsigned den;
        longint unsigned g;
        num = deg;
        num = (num << FRAC_SH) + res;
        den = res;
        den = 2 * den;
        if (res == 0)
        begin
            g = top;
        end
        else
        begin
            g = num / den + zero;
            if (g > top)
            begin
                g = top;
            end
        end
        if (g < zero)
        begin
            g = zero;
        end
        return g[CNT_W-1:0];
    endfunction

    // A move starts only when the error is strictly larger than the dead zone.
    function automatic bit beyond_dead_zone(input int s, input int g, input int dz);
        int err;
        err = (s > g) ? s - g : g - s;
        return err > dz;
    endfunction

    // Readback: counts above the zero times the Q0.16 resolution, truncated
    // and clamped to the axis limit.
    function automatic int sample_degrees(input int unsigned s, input int unsigned zero,
                                          input int unsigned res, input int lim);
        longint unsigned d;
        if (s <= zero)
        begin
            return 0;
        end
        d = s - zero;
        d = (d * res) >> RES_W;
        return (d > lim) ? lim : int'(d);
    endfunction

    // Advances the predicted positioner by one input item and returns its result.
    function automatic drive_word_t step_positioner(input logic op,
                                                    input logic [CNT_W-1:0] az_s,
                                                    input logic [CNT_W-1:0] el_s,
                                                    input logic [AZ_TGT_W-1:0] azt,
                                                    input logic [EL_TGT_W-1:0] elt);
        drive_word_t r;
        r = '0;
        if (op == OP_CMD)
        begin
            // A command replaces any motion in progress. When azimuth is
            // already inside its dead zone, elevation is checked at once.
            az_goal_p = goal_count(azt, az_res_c, az_zero_c, az_max_c);
            el_goal_p = goal_count(elt, el_res_c, el_zero_c, el_max_c);
            motion_p = beyond_dead_zone(az_s, az_goal_p, az_dz_c) ? MV_AZ : MV_EL;
            if (motion_p == MV_EL && !beyond_dead_zone(el_s, el_goal_p, el_dz_c))
            begin
                motion_p = MV_IDLE;
            end
        end
        else if (motion_p == MV_AZ && az_s == az_goal_p)
        begin
            // Azimuth has arrived exactly; elevation is checked in the same item.
            motion_p = beyond_dead_zone(el_s, el_goal_p, el_dz_c) ? MV_EL : MV_IDLE;
        end
        case (motion_p)
            MV_AZ:
            begin
                r.east = az_s < az_goal_p;
                r.west = az_s > az_goal_p;
            end
            MV_EL:
            begin
                if (el_s < el_goal_p)
                begin
                    r.up = 1'b1;
                end
                else if (el_s > el_goal_p)
                begin
                    r.down = 1'b1;
                end
                else
                begin
                    motion_p = MV_IDLE;
                end
            end
            default:
            begin
            end
        endcase
        r.busy   = motion_p != MV_IDLE;
        r.az_deg = AZ_DEG_W'(sample_degrees(az_s, az_zero_c, az_res_c, AZ_DEG_MAX));
        r.el_deg = EL_DEG_W'(sample_degrees(el_s, el_zero_c, el_res_c, EL_DEG_MAX));
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(input int v);
        return CNT_W'((v < 0) ? 0 : ((v > CNT_TOP) ? CNT_TOP : v));
    endfunction

    // Moves a position toward its goal by a random stride. Most strides land
    // on the goal or short of it; now and then the antenna overshoots.
    function automatic logic [CNT_W-1:0] approach(input int pos, input int goal);
        int span;
        int stride;
        span = (pos > goal) ? pos - goal : goal - pos;
        stride = $urandom_range(span / 2 + 3, 1);
        if (stride > span && $urandom_range(3) != 0)
        begin
            stride = span;
        end
        return clamp_count((pos < goal) ? pos + stride : pos - stride);
    endfunction

    // A sample just inside or just outside the dead zone around a goal.
    function automatic logic [CNT_W-1:0] near_goal(input int goal, input int dz);
        int off;
        off = dz + int'($urandom_range(1));
        return clamp_count(($urandom_range(1) != 0) ? goal + off : goal - off);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Scoreboard and run limit. Results are compared before new items are
    // predicted, since a result never belongs to an item taken at the same edge.
    always @(posedge clk)
    begin : scoreboard
        drive_word_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (drive_words_due.size() == 0)
                begin
                    $error("result item arrived with no input item pending");
                    errors++;
                end
                else
                begin
                    want = drive_words_due.pop_front();
                    check_field("drive_east", want.east, drive_east);
                    check_field("drive_west", want.west, drive_west);
                    check_field("drive_up", want.up, drive_up);
                    check_field("drive_down", want.down, drive_down);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("az_degrees", want.az_deg, az_degrees);
                    check_field("el_degrees", want.el_deg, el_degrees);
                end
            end
            if (in_valid && in_ready)
            begin
                want = step_positioner(operation, az_sample, el_sample,
                                       az_target_deg, el_target_deg);
                if (row_typed)
                begin
                    want = row_want;
                end
                drive_words_due.push_back(want);
            end
        end
    end

    // The receiver stalls at random, except in the stretch without idling,
    // and once holds off for a long while so that the positioner backs up.
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready = !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Waits for the next falling edge, leaving random gaps on the input side.
    task automatic next_slot();
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
    endtask

    // Offers one item and holds it steady until the positioner takes it.
    task automatic offer_item(input op_t op, input logic [CNT_W-1:0] az,
                              input logic [CNT_W-1:0] el,
                              input logic [AZ_TGT_W-1:0] azt,
                              input logic [EL_TGT_W-1:0] elt,
                              input bit typed, input drive_word_t want);
        row_typed     = typed;
        row_want      = want;
        operation     = op;
        az_sample     = az;
        el_sample     = el;
        az_target_deg = azt;
        el_target_deg = elt;
        in_valid      = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic add_row(input op_t op, input int az, input int el, input int azt,
                           input int elt, input bit typed, input drive_word_t want);
        table_row_t r;
        r.op    = op;
        r.az    = CNT_W'(az);
        r.el    = CNT_W'(el);
        r.azt   = AZ_TGT_W'(azt);
        r.elt   = EL_TGT_W'(elt);
        r.typed = typed;
        r.want  = want;
        script.push_back(r);
    endtask

    // One random item. Most items play out a believable session: a command,
    // then sample ticks that follow the antenna as the drive lines move it.
    // The rest are commands that cut into a motion and pure noise.
    task automatic random_item();
        int                  pick;
        logic [AZ_TGT_W-1:0] azt;
        logic [EL_TGT_W-1:0] elt;
        next_slot();
        pick = $urandom_range(99);
        azt  = AZ_TGT_W'($urandom);
        elt  = EL_TGT_W'($urandom);
        if (pick < 8)
        begin
            offer_item(op_t'($urandom_range(1)), CNT_W'($urandom), CNT_W'($urandom),
                       azt, elt, 1'b0, '0);
        end
        else if ((motion_p == MV_IDLE && pick < 78) || pick < 13)
        begin
            // Now and then the antenna already sits at the rim of the dead
            // zone around the new goals, so both sides of the rim are tried.
            if ($urandom_range(3) == 0)
            begin
                az_pos = near_goal(goal_count(azt, az_res_c, az_zero_c, az_max_c), az_dz_c);
                el_pos = near_goal(goal_count(elt, el_res_c, el_zero_c, el_max_c), el_dz_c);
            end
            offer_item(OP_CMD, az_pos, el_pos, azt, elt, 1'b0, '0);
        end
        else
        begin
            if (motion_p == MV_AZ)
            begin
                az_pos = approach(az_pos, az_goal_p);
            end
            else if (motion_p == MV_EL)
            begin
                el_pos = approach(el_pos, el_goal_p);
            end
            else
            begin
                az_pos = clamp_count(int'(az_pos) + int'($urandom_range(6)) - 3);
                el_pos = clamp_count(int'(el_pos) + int'($urandom_range(6)) - 3);
            end
            offer_item(OP_TICK, az_pos, el_pos, azt, elt, 1'b0, '0);
        end
    endtask

    // Writes all eight registers once the positioner has delivered every
    // result it owes, keeping the shadow copy in step.
    task automatic configure(input int az0, input int azm, input int azdz, input int azr,
                             input int el0, input int elm, input int eldz, input int elr);
        logic [CFG_W-1:0] vals[8];
        logic [CFG_W-1:0] v;
        cfg_idx_t         idx;
        vals = '{CFG_W'(az0), CFG_W'(azm), CFG_W'(azdz), CFG_W'(azr),
                 CFG_W'(el0), CFG_W'(elm), CFG_W'(eldz), CFG_W'(elr)};
        @(negedge clk);
        in_valid = 1'b0;
        while (drive_words_due.size() != 0)
        begin
            @(negedge clk);
        end
        idx = idx.first();
        do
        begin
            v = vals[idx];
            cfg_write = 1'b1;
            cfg_index = idx;
            cfg_data  = v;
            case (idx)
                CFG_AZ_ZERO: az_zero_c = v[CNT_W-1:0];
                CFG_AZ_MAX:  az_max_c  = v[CNT_W-1:0];
                CFG_AZ_DZ:   az_dz_c   = v[CNT_W-1:0];
                CFG_AZ_RES:  az_res_c  = v[RES_W-1:0];
                CFG_EL_ZERO: el_zero_c = v[CNT_W-1:0];
                CFG_EL_MAX:  el_max_c  = v[CNT_W-1:0];
                CFG_EL_DZ:   el_dz_c   = v[CNT_W-1:0];
                default:     el_res_c  = v[RES_W-1:0];
            endcase
            @(negedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_write = 1'b0;
    endtask

    initial
    begin : stimulus
        int zero;
        cfg_write     = 1'b0;
        cfg_index     = CFG_AZ_ZERO;
        cfg_data      = '0;
        in_valid      = 1'b0;
        operation     = OP_TICK;
        az_sample     = '0;
        el_sample     = '0;
        az_target_deg = '0;
        el_target_deg = '0;
        row_typed     = 1'b0;
        row_want      = '0;
        az_pos        = '0;
        el_pos        = '0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        errors        = 0;
        cycles        = 0;

        // The shadow registers and the predicted state start from the reset values.
        az_zero_c = CNT_W'(ZERO_RST);
        az_max_c  = CNT_W'(MAX_RST);
        az_dz_c   = CNT_W'(DZ_RST);
        az_res_c  = RES_W'(AZ_RES_RST);
        el_zero_c = CNT_W'(ZERO_RST);
        el_max_c  = CNT_W'(MAX_RST);
        el_dz_c   = CNT_W'(DZ_RST);
        el_res_c  = RES_W'(EL_RES_RST);
        az_goal_p = '0;
        el_goal_p = '0;
        motion_p  = MV_IDLE;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table with the reset configuration. Typed results list the
        // drive lines as {east, west, up, down}, then busy and both readbacks.
        // A tick straight after reset: nothing moves, both readbacks are zero.
        add_row(OP_TICK, 0, 0, 0, 0, 1'b1, {4'b0000, 1'b0, 9'd0, 8'd0});
        // Full-scale samples read back clamped to 450 and 180 degrees.
        add_row(OP_TICK, CNT_TOP, CNT_TOP, 0, 0, 1'b1, {4'b0000, 1'b0, 9'd450, 8'd180});
        // A command to zero degrees while already there needs no move at all.
        add_row(OP_CMD, 0, 0, 0, 0, 1'b1, {4'b0000, 1'b0, 9'd0, 8'd0});
        // The largest targets clamp both goals to the max count; azimuth drives east.
        add_row(OP_CMD, 0, 0, 511, 255, 1'b1, {4'b1000, 1'b1, 9'd0, 8'd0});
        add_row(OP_TICK, 512, 0, 0, 0, 1'b0, '0);
        // Azimuth arrives exactly; elevation starts driving up in the same item.
        add_row(OP_TICK, CNT_TOP, 0, 0, 0, 1'b1, {4'b0010, 1'b1, 9'd450, 8'd0});
        // Elevation arrives and the positioner goes idle.
        add_row(OP_TICK, CNT_TOP, CNT_TOP, 0, 0, 1'b1, {4'b0000, 1'b0, 9'd450, 8'd180});
        // A mid-range command from the top end drives west, then down, then stops.
        add_row(OP_CMD, CNT_TOP, CNT_TOP, 90, 45, 1'b0, '0);
        add_row(OP_TICK, 205, CNT_TOP, 0, 0, 1'b0, '0);
        add_row(OP_TICK, 205, 256, 0, 0, 1'b0, '0);
        // Errors equal to the dead zone start nothing; one count more does.
        add_row(OP_CMD, 209, 252, 90, 45, 1'b0, '0);
        add_row(OP_CMD, 210, 256, 90, 45, 1'b0, '0);
        // A new command replaces the azimuth move that is under way.
        add_row(OP_CMD, 210, 256, 0, 0, 1'b0, '0);
        // Azimuth inside its dead zone hands over to elevation in the same item.
        add_row(OP_CMD, 201, 261, 90, 45, 1'b0, '0);
        add_row(OP_TICK, 100, 256, 0, 0, 1'b0, '0);
        add_row(OP_CMD, 205, 0, 90, 90, 1'b0, '0);
        add_row(OP_TICK, 205, 511, 0, 0, 1'b0, '0);
        // A tick while idle only changes the readback.
        add_row(OP_TICK, 300, 300, 0, 0, 1'b0, '0);
        foreach (script[i])
        begin
            next_slot();
            offer_item(script[i].op, script[i].az, script[i].el, script[i].azt,
                       script[i].elt, script[i].typed, script[i].want);
        end
        repeat (RANDOM_PER_PHASE) random_item();

        // Wide goals, zero dead zones and the finest and coarsest resolutions,
        // run as one long stretch without idling on either side.
        configure(100, 900, 0, 65535, 50, 700, 0, 1);
        idle_on = 1'b0;
        repeat (RANDOM_PER_PHASE) random_item();
        idle_on = 1'b1;

        // Zero count above the max count, zero resolution and the widest dead zone.
        configure(CNT_TOP, 0, CNT_TOP, 0, 0, CNT_TOP, CNT_TOP, 65535);
        repeat (RANDOM_PER_PHASE) random_item();

        // Smallest resolution and dead zone on azimuth, zero resolution on
        // elevation. The receiver holds off for a long stretch in this phase.
        configure(0, CNT_TOP, 1, 1, CNT_TOP, CNT_TOP, 0, 0);
        hold_req = 1'b1;
        repeat (RANDOM_PER_PHASE) random_item();

        // Random settings around a return to the reset values.
        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                configure(ZERO_RST, MAX_RST, DZ_RST, AZ_RES_RST,
                          ZERO_RST, MAX_RST, DZ_RST, EL_RES_RST);
            end
            else
            begin
                zero = $urandom_range(400);
                configure(zero, $urandom_range(CNT_TOP, zero),
                          $urandom_range(12), $urandom_range(65535, 1),
                          zero / 2, $urandom_range(CNT_TOP, zero / 2),
                          $urandom_range(12), $urandom_range(65535, 1));
            end
            repeat (RANDOM_PER_PHASE) random_item();
        end

        // Let every owed result drain, then give stray results time to show up.
        @(negedge clk);
        in_valid = 1'b0;
        while (drive_words_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/rpbb_pkg.sv
design/rpbb_cfg_regs.sv
design/rpbb_div.sv
design/rotator_position_bang_bang.sv
tb/sv/tb_top.sv
